// ----- rtl/core/euler_rotation_matrix_macros.svh -----
// ----------------------------------------------------------------------------
// euler_rotation_matrix assertion macros
// Concurrent checks on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef EULER_ROTATION_MATRIX_MACROS_SVH
`define EULER_ROTATION_MATRIX_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ERM_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("erm check failed");
`define ERM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("erm check failed");
`else
`define ERM_ASSERT_IMPLY(label, ante, cons)
`define ERM_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- rtl/core/erm_pkg.sv -----
// ----------------------------------------------------------------------------
// erm_pkg
// Shared widths and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package erm_pkg;

    localparam int ANG_W        = 16;   // input angle field width
    localparam int OUT_W        = 16;   // output entry width
    localparam int CW           = 32;   // Q2.30 datapath width
    localparam int CORDIC_STEPS = 28;
    localparam int LANES        = 3;

    localparam logic signed [CW-1:0] GAIN_INV = 32'sd652032875;
    localparam logic signed [CW-1:0] QTR_HALF = 32'sd536870912;   // 2^29

    // atan(2^-i), 2^32 units per turn
    localparam logic signed [CW-1:0] ATAN_TAB [0:CORDIC_STEPS-1] = '{
        32'sh20000000, 32'sh12E4051E, 32'sh09FB385B, 32'sh051111D4,
        32'sh028B0D43, 32'sh0145D7E1, 32'sh00A2F61E, 32'sh00517C55,
        32'sh0028BE53, 32'sh00145F2F, 32'sh000A2F98, 32'sh000517CC,
        32'sh00028BE6, 32'sh000145F3, 32'sh0000A2FA, 32'sh0000517D,
        32'sh000028BE, 32'sh0000145F, 32'sh00000A30, 32'sh00000518,
        32'sh0000028C, 32'sh00000146, 32'sh000000A3, 32'sh00000051,
        32'sh00000029, 32'sh00000014, 32'sh0000000A, 32'sh00000005
    };

endpackage

// ----- rtl/core/erm_cordic.sv -----
// ----------------------------------------------------------------------------
// erm_cordic
// Three-lane unrolled CORDIC rotator, one iteration per register stage.
// ----------------------------------------------------------------------------
module erm_cordic
    import erm_pkg::*;
#(
    parameter int ANGLE_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [ANG_W-1:0]     i_angle [LANES],
    output logic                 o_valid,
    output logic signed [CW-1:0] o_cos [LANES],
    output logic signed [CW-1:0] o_sin [LANES]
);

    localparam logic [CW-1:0] AMASK = CW'((64'd1 << ANGLE_BITS) - 64'd1);
    localparam int            ASH   = CW - ANGLE_BITS;

    logic signed [CW-1:0] r_x [LANES][0:CORDIC_STEPS];
    logic signed [CW-1:0] r_y [LANES][0:CORDIC_STEPS];
    logic signed [CW-1:0] r_z [LANES][0:CORDIC_STEPS];
    logic [1:0]           r_q [LANES][0:CORDIC_STEPS];
    logic [CORDIC_STEPS+1:0] r_v;   // stage valids, top bit is the output stage

    logic [CW-1:0]        w_b [LANES];

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            w_b[l] = CW'(((CW'(i_angle[l]) & AMASK) << ASH) + 32'h2000_0000);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[CORDIC_STEPS:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int l = 0; l < LANES; l++) begin
                r_x[l][0] <= GAIN_INV;
                r_y[l][0] <= '0;
                r_z[l][0] <= $signed({2'b00, w_b[l][29:0]}) - QTR_HALF;
                r_q[l][0] <= w_b[l][31:30];
                for (int s = 0; s < CORDIC_STEPS; s++) begin
                    r_q[l][s+1] <= r_q[l][s];
                    if (!r_z[l][s][CW-1]) begin
                        r_x[l][s+1] <= r_x[l][s] - (r_y[l][s] >>> s);
                        r_y[l][s+1] <= r_y[l][s] + (r_x[l][s] >>> s);
                        r_z[l][s+1] <= r_z[l][s] - ATAN_TAB[s];
                    end else begin
                        r_x[l][s+1] <= r_x[l][s] + (r_y[l][s] >>> s);
                        r_y[l][s+1] <= r_y[l][s] - (r_x[l][s] >>> s);
                        r_z[l][s+1] <= r_z[l][s] + ATAN_TAB[s];
                    end
                end
                // quarter-turn fold
                case (r_q[l][CORDIC_STEPS])
                    2'd0: begin
                        o_cos[l] <= r_x[l][CORDIC_STEPS];
                        o_sin[l] <= r_y[l][CORDIC_STEPS];
                    end
                    2'd1: begin
                        o_cos[l] <= -r_y[l][CORDIC_STEPS];
                        o_sin[l] <= r_x[l][CORDIC_STEPS];
                    end
                    2'd2: begin
                        o_cos[l] <= -r_x[l][CORDIC_STEPS];
                        o_sin[l] <= -r_y[l][CORDIC_STEPS];
                    end
                    default: begin
                        o_cos[l] <= r_y[l][CORDIC_STEPS];
                        o_sin[l] <= -r_x[l][CORDIC_STEPS];
                    end
                endcase
            end
        end
    end

    assign o_valid = r_v[CORDIC_STEPS+1];

endmodule

// ----- rtl/core/euler_rotation_matrix.sv -----
// Pipeline: the CORDIC stages, then the multiply and round stages m1, r1, m2, r2 and the output register.
// Throughput: one beat per cycle; the whole pipeline advances when the output
// register is empty or being taken, so i_m_tready sets the sustained rate.
// Reset: synchronous, active low; clears all stage valids, payload is not reset.
// ----------------------------------------------------------------------------
// euler_rotation_matrix
// Z*X*Y Euler angles to 3x3 rotation matrix, saturated signed fractions.
// ----------------------------------------------------------------------------
`include "euler_rotation_matrix_macros.svh"

module euler_rotation_matrix
    import erm_pkg::*;
#(
    parameter int ANGLE_BITS    = 16,
    parameter int FRACTION_BITS = 14
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [47:0]  i_s_tdata,   // angle_x, angle_y, angle_z
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // row0_col0, row0_col1, row0_col2, row1_col0, row1_col1, row1_col2,
    // row2_col0, row2_col1, row2_col2
    output logic [143:0] o_m_tdata
);

    localparam int                   SH   = 30 - FRACTION_BITS;
    localparam logic signed [34:0]   HALF = 35'((64'd1 << SH) >> 1);
    localparam logic signed [34:0]   ONE  = 35'(64'd1 << FRACTION_BITS);
    localparam logic signed [63:0]   RND  = 64'sd536870912;

    function automatic logic signed [CW-1:0] rnd30(input logic signed [63:0] p);
        logic signed [63:0] t;
        t = p + RND;
        return t[61:30];
    endfunction

    function automatic logic [OUT_W-1:0] to_out(input logic signed [32:0] v);
        logic signed [34:0] r;
        r = (35'(v) + HALF) >>> SH;
        if (r > ONE) r = ONE;
        if (r < -ONE) r = -ONE;
        return r[OUT_W-1:0];
    endfunction

    logic                 w_en;
    logic [ANG_W-1:0]     w_ang [LANES];
    logic                 w_cs_valid;
    logic signed [CW-1:0] w_cos [LANES];
    logic signed [CW-1:0] w_sin [LANES];

    // stage valids
    logic r_v_m1, r_v_r1, r_v_m2, r_v_r2, r_v_out;

    // first products, raw then rounded
    logic signed [63:0]   r_p_czcy, r_p_sxsy, r_p_czsy, r_p_sxcy, r_p_szcy;
    logic signed [63:0]   r_p_szsy, r_p_szcx, r_p_czcx, r_p_cxsy, r_p_cxcy;
    logic signed [CW-1:0] r_m1_sx, r_m1_sz, r_m1_cz;
    logic signed [CW-1:0] r_q_czcy, r_q_sxsy, r_q_czsy, r_q_sxcy, r_q_szcy;
    logic signed [CW-1:0] r_q_szsy, r_q_szcx, r_q_czcx, r_q_cxsy, r_q_cxcy;
    logic signed [CW-1:0] r_r1_sx, r_r1_sz, r_r1_cz;

    // triple products
    logic signed [63:0]   r_t_a, r_t_b, r_t_c, r_t_d;
    logic signed [CW-1:0] r_u_a, r_u_b, r_u_c, r_u_d;
    logic signed [CW-1:0] r_m2_czcy, r_m2_czsy, r_m2_szcy, r_m2_szsy;
    logic signed [CW-1:0] r_m2_szcx, r_m2_czcx, r_m2_cxsy, r_m2_cxcy, r_m2_sx;
    logic signed [CW-1:0] r_r2_czcy, r_r2_czsy, r_r2_szcy, r_r2_szsy;
    logic signed [CW-1:0] r_r2_szcx, r_r2_czcx, r_r2_cxsy, r_r2_cxcy, r_r2_sx;

    logic [143:0]         r_out;

    assign w_en       = !r_v_out || i_m_tready;
    assign o_s_tready = w_en;
    assign w_ang[0]   = i_s_tdata[15:0];
    assign w_ang[1]   = i_s_tdata[31:16];
    assign w_ang[2]   = i_s_tdata[47:32];

    erm_cordic #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_s_tvalid),
        .i_angle (w_ang),
        .o_valid (w_cs_valid),
        .o_cos   (w_cos),
        .o_sin   (w_sin)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_m1  <= 1'b0;
            r_v_r1  <= 1'b0;
            r_v_m2  <= 1'b0;
            r_v_r2  <= 1'b0;
            r_v_out <= 1'b0;
        end else if (w_en) begin
            r_v_m1  <= w_cs_valid;
            r_v_r1  <= r_v_m1;
            r_v_m2  <= r_v_r1;
            r_v_r2  <= r_v_m2;
            r_v_out <= r_v_r2;
        end
    end

    // lanes: 0 = x, 1 = y, 2 = z
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p_czcy <= w_cos[2] * w_cos[1];
            r_p_sxsy <= w_sin[0] * w_sin[1];
            r_p_czsy <= w_cos[2] * w_sin[1];
            r_p_sxcy <= w_sin[0] * w_cos[1];
            r_p_szcy <= w_sin[2] * w_cos[1];
            r_p_szsy <= w_sin[2] * w_sin[1];
            r_p_szcx <= w_sin[2] * w_cos[0];
            r_p_czcx <= w_cos[2] * w_cos[0];
            r_p_cxsy <= w_cos[0] * w_sin[1];
            r_p_cxcy <= w_cos[0] * w_cos[1];
            r_m1_sx  <= w_sin[0];
            r_m1_sz  <= w_sin[2];
            r_m1_cz  <= w_cos[2];

            r_q_czcy <= rnd30(r_p_czcy);
            r_q_sxsy <= rnd30(r_p_sxsy);
            r_q_czsy <= rnd30(r_p_czsy);
            r_q_sxcy <= rnd30(r_p_sxcy);
            r_q_szcy <= rnd30(r_p_szcy);
            r_q_szsy <= rnd30(r_p_szsy);
            r_q_szcx <= rnd30(r_p_szcx);
            r_q_czcx <= rnd30(r_p_czcx);
            r_q_cxsy <= rnd30(r_p_cxsy);
            r_q_cxcy <= rnd30(r_p_cxcy);
            r_r1_sx  <= r_m1_sx;
            r_r1_sz  <= r_m1_sz;
            r_r1_cz  <= r_m1_cz;

            r_t_a     <= r_r1_sz * r_q_sxsy;
            r_t_b     <= r_r1_cz * r_q_sxsy;
            r_t_c     <= r_r1_sz * r_q_sxcy;
            r_t_d     <= r_r1_cz * r_q_sxcy;
            r_m2_czcy <= r_q_czcy;
            r_m2_czsy <= r_q_czsy;
            r_m2_szcy <= r_q_szcy;
            r_m2_szsy <= r_q_szsy;
            r_m2_szcx <= r_q_szcx;
            r_m2_czcx <= r_q_czcx;
            r_m2_cxsy <= r_q_cxsy;
            r_m2_cxcy <= r_q_cxcy;
            r_m2_sx   <= r_r1_sx;

            r_u_a     <= rnd30(r_t_a);
            r_u_b     <= rnd30(r_t_b);
            r_u_c     <= rnd30(r_t_c);
            r_u_d     <= rnd30(r_t_d);
            r_r2_czcy <= r_m2_czcy;
            r_r2_czsy <= r_m2_czsy;
            r_r2_szcy <= r_m2_szcy;
            r_r2_szsy <= r_m2_szsy;
            r_r2_szcx <= r_m2_szcx;
            r_r2_czcx <= r_m2_czcx;
            r_r2_cxsy <= r_m2_cxsy;
            r_r2_cxcy <= r_m2_cxcy;
            r_r2_sx   <= r_m2_sx;

            r_out <= {
                to_out(33'(r_r2_cxcy)),
                to_out(33'(r_r2_sx)),
                to_out(-33'(r_r2_cxsy)),
                to_out(33'(r_r2_szsy) - 33'(r_u_d)),
                to_out(33'(r_r2_czcx)),
                to_out(33'(r_r2_szcy) + 33'(r_u_b)),
                to_out(33'(r_r2_czsy) + 33'(r_u_c)),
                to_out(-33'(r_r2_szcx)),
                to_out(33'(r_r2_czcy) - 33'(r_u_a))
            };
        end
    end

    assign o_m_tvalid = r_v_out;
    assign o_m_tdata  = r_out;

    // a held result freezes the whole pipe
    `ERM_ASSERT_IMPLY(a_stall_blocks_input, r_v_out && !i_m_tready, !o_s_tready)
    // CORDIC outputs stay near the unit circle
    `ERM_ASSERT_IMPLY(a_cos_bounded, r_v_m1, r_m1_cz <= 32'sd1073750000 && r_m1_cz >= -32'sd1073750000)
    // an item leaving the CORDIC lands in the first multiply stage
    `ERM_ASSERT_NEXT(a_cs_to_mult, w_en && w_cs_valid, r_v_m1)

endmodule

// ----- bench/euler_rotation_matrix_tb.sv -----
// ----------------------------------------------------------------------------
// euler_rotation_matrix_tb
// Drives angle triples into the rotation matrix block, predicts each matrix
// with a local CORDIC and fixed-point product model, and compares every entry.
// ----------------------------------------------------------------------------
module euler_rotation_matrix_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_tvalid = 1'b0;
    logic         o_s_tready;
    logic [47:0]  i_s_tdata = '0;
    logic         o_m_tvalid;
    logic         i_m_tready = 1'b0;
    logic [143:0] o_m_tdata;

    logic [143:0] matrix_q[$];
    int           error_count = 0;
    int           beats_in = 0;
    int           beats_out = 0;
    int           idle_cycles = 0;
    bit           hold_off = 1'b0;
    bit           stall_free = 1'b0;

    euler_rotation_matrix u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always #5 i_clk = ~i_clk;

    localparam longint ATAN_STEP [0:27] = '{
        'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4,
        'h028B0D43, 'h0145D7E1, 'h00A2F61E, 'h00517C55,
        'h0028BE53, 'h00145F2F, 'h000A2F98, 'h000517CC,
        'h00028BE6, 'h000145F3, 'h0000A2FA, 'h0000517D,
        'h000028BE, 'h0000145F, 'h00000A30, 'h00000518,
        'h0000028C, 'h00000146, 'h000000A3, 'h00000051,
        'h00000029, 'h00000014, 'h0000000A, 'h00000005
    };

    task automatic angle_cos_sin(input logic [15:0] ang, output longint c, output longint s);
        logic [31:0] b;
        longint      x, y, z, dx, dy;
        b = {ang, 16'h0} + 32'h2000_0000;
        z = longint'(b[29:0]) - 64'sd536870912;
        x = 652032875;
        y = 0;
        for (int i = 0; i < 28; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= ATAN_STEP[i];
            end else begin
                x += dx; y -= dy; z += ATAN_STEP[i];
            end
        end
        case (b[31:30])
            2'd0: begin c = x;  s = y;  end
            2'd1: begin c = -y; s = x;  end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endtask

    function automatic longint mq(longint a, longint b);
        return (a * b + (64'sd1 <<< 29)) >>> 30;
    endfunction

    function automatic logic [15:0] entry_q14(longint v);
        longint r;
        r = (v + (64'sd1 <<< 15)) >>> 16;
        if (r > 16384) r = 16384;
        if (r < -16384) r = -16384;
        return r[15:0];
    endfunction

    task automatic predict_matrix(input logic [47:0] angles, output logic [143:0] m);
        longint cx, sx, cy, sy, cz, sz;
        angle_cos_sin(angles[15:0], cx, sx);
        angle_cos_sin(angles[31:16], cy, sy);
        angle_cos_sin(angles[47:32], cz, sz);
        m[15:0]    = entry_q14(mq(cz, cy) - mq(sz, mq(sx, sy)));
        m[31:16]   = entry_q14(-mq(sz, cx));
        m[47:32]   = entry_q14(mq(cz, sy) + mq(sz, mq(sx, cy)));
        m[63:48]   = entry_q14(mq(sz, cy) + mq(cz, mq(sx, sy)));
        m[79:64]   = entry_q14(mq(cz, cx));
        m[95:80]   = entry_q14(mq(sz, sy) - mq(cz, mq(sx, cy)));
        m[111:96]  = entry_q14(-mq(cx, sy));
        m[127:112] = entry_q14(sx);
        m[143:128] = entry_q14(mq(cx, cy));
    endtask

    // sender: one beat, with valid held until accepted
    task automatic send_angles(input logic [15:0] ax, ay, az);
        logic [143:0] m;
        predict_matrix({az, ay, ax}, m);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {az, ay, ax};
        do @(posedge i_clk); while (!o_s_tready);
        matrix_q.push_back(m);
        beats_in++;
    endtask

    task automatic sender_gap();
        i_s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge i_clk);
    endtask

    // valid may be left high at the end; the caller sends again or drains
    task automatic send_burst_random(input int n, input bit special);
        int left, burst;
        logic [15:0] a[3];
        left = n;
        while (left > 0) begin
            burst = $urandom_range(1, 30);
            for (int k = 0; k < burst && left > 0; k++, left--) begin
                for (int j = 0; j < 3; j++) begin
                    case (special ? $urandom_range(0, 3) : 3)
                        0: a[j] = 16'(16'h4000 * $urandom_range(0, 3));
                        1: a[j] = 16'(16'h4000 * $urandom_range(0, 3) + $urandom_range(0, 4)
                                 - 2);
                        2: a[j] = 16'(16'h2000 * $urandom_range(0, 7));
                        default: a[j] = 16'($urandom);
                    endcase
                end
                send_angles(a[0], a[1], a[2]);
            end
            if ($urandom_range(0, 3) != 0) sender_gap();
        end
    endtask

    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        while (matrix_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed();
        logic [15:0] edges[8] = '{16'h0000, 16'hFFFF, 16'h4000, 16'h8000,
                                   16'hC000, 16'h2000, 16'h5555, 16'hAAAA};
        for (int i = 0; i < 8; i++) send_angles(edges[i], edges[i], edges[i]);
        for (int i = 0; i < 8; i++) send_angles(edges[i], edges[(i+3)%8], edges[(i+5)%8]);
        send_angles(16'h4000, 16'h0000, 16'h0000);   // sx = +1, clamp path
        send_angles(16'hC000, 16'h0000, 16'h0000);   // sx = -1
        send_angles(16'h3FFF, 16'h4001, 16'hBFFF);
        wait_drained();
    endtask

    task automatic test_backpressure();
        hold_off = 1'b1;
        fork
            send_burst_random(120, 1'b0);
            begin
                repeat (300) @(posedge i_clk);
                hold_off = 1'b0;
            end
        join
        wait_drained();
    endtask

    task automatic test_random();
        send_burst_random(700, 1'b1);
        wait_drained();   // sender pauses until all matrices are back
        stall_free = 1'b1;
        send_burst_random(200, 1'b0);
        stall_free = 1'b0;
        send_burst_random(700, 1'b0);
        wait_drained();
    endtask

    // receiver stall pattern: random runs of ready / not ready
    initial begin
        int run;
        forever begin
            run = $urandom_range(1, 12);
            for (int k = 0; k < run; k++) begin
                @(posedge i_clk);
                i_m_tready <= !hold_off && (stall_free || run[0] || $urandom_range(0, 1));
            end
        end
    end

    always @(posedge i_clk) begin
        logic [143:0] want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            beats_out++;
            if (matrix_q.size() == 0) begin
                $display("%0t: unexpected beat, actual %h", $time, o_m_tdata);
                error_count++;
            end else begin
                want = matrix_q.pop_front();
                for (int e = 0; e < 9; e++)
                    if (want[e*16 +: 16] !== o_m_tdata[e*16 +: 16]) begin
                        $display("%0t: entry %0d expected %0d actual %0d", $time, e,
                                 $signed(want[e*16 +: 16]), $signed(o_m_tdata[e*16 +: 16]));
                        error_count++;
                    end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("euler_rotation_matrix verification failed");
            $finish;
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_backpressure();
        test_random();
        repeat (100) @(posedge i_clk);
        $display("%0d angle triples sent, %0d matrices checked, with stalls and backpressure",
                 beats_in, beats_out);
        if (error_count == 0 && matrix_q.size() == 0)
            $display("euler_rotation_matrix verification clean");
        else
            $display("euler_rotation_matrix verification failed");
        $finish;
    end
endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/erm_pkg.sv
rtl/core/erm_cordic.sv
rtl/core/euler_rotation_matrix.sv
bench/euler_rotation_matrix_tb.sv
